FILE: rtl/core/tge_pkg.sv
// ----------------------------------------------------------------------------
// tge_pkg: shared types and constants of the tensor gather engine
// Operation, status and register codes, and the shared unit's operation type.
// ----------------------------------------------------------------------------
package tge_pkg;

  // Tensor shape limits
  localparam int MAX_RANK = 4;
  localparam int DIM_W    = 16;
  localparam int RANK_W   = 3;

  // Default store geometry
  localparam int DATA_DEPTH_DEF    = 4096;
  localparam int INDEX_DEPTH_DEF   = 1024;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Width of the saturating unit; values saturate at 2**16
  localparam int UNIT_W = 17;
  localparam logic [UNIT_W-1:0] SAT_VAL = 17'h10000;

  // Request operations
  localparam logic [1:0] OP_WR_DATA  = 2'd0;
  localparam logic [1:0] OP_WR_INDEX = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ADDR  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_DATA_RANK   = 3'd0;
  localparam logic [2:0] REG_DATA_DIMS   = 3'd1;
  localparam logic [2:0] REG_INDEX_RANK  = 3'd2;
  localparam logic [2:0] REG_INDEX_DIMS  = 3'd3;
  localparam logic [2:0] REG_GATHER_AXIS = 3'd4;
  localparam logic [2:0] REG_BATCH_COUNT = 3'd5;

  // Shared unit operations
  typedef enum logic [0:0] {
    UNIT_MAC = 1'b0,
    UNIT_DIV = 1'b1
  } unit_op_e;

endpackage

FILE: rtl/core/tge_ram.sv
// ----------------------------------------------------------------------------
// tge_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/tge_unit.sv
// ----------------------------------------------------------------------------
// tge_unit: shared arithmetic unit of the gather engine
// Saturating multiply-add for sizes and linear addresses, and one step of a
// restoring divider for splitting the output index.
// ----------------------------------------------------------------------------
module tge_unit (
  input  tge_pkg::unit_op_e          op_i,
  input  logic [tge_pkg::UNIT_W-1:0] a_i,
  input  logic [tge_pkg::UNIT_W-1:0] b_i,
  input  logic [tge_pkg::UNIT_W-1:0] c_i,
  output logic [tge_pkg::UNIT_W-1:0] res_o,
  output logic                       flag_o
);
  import tge_pkg::*;

  logic [2*UNIT_W-1:0] prod;
  logic [2*UNIT_W:0]   sum;
  logic [UNIT_W-1:0]   trial;

  assign prod  = a_i * b_i;
  assign sum   = {1'b0, prod} + (2*UNIT_W+1)'(c_i);
  assign trial = {a_i[UNIT_W-2:0], c_i[0]};

  // Select multiply-add with saturation or a divide step
  always_comb begin
    res_o  = '0;
    flag_o = 1'b0;
    unique case (op_i)
      UNIT_MAC: begin
        res_o = (sum > (2*UNIT_W+1)'(SAT_VAL)) ? SAT_VAL : sum[UNIT_W-1:0];
      end
      UNIT_DIV: begin
        if (trial >= b_i) begin
          res_o  = trial - b_i;
          flag_o = 1'b1;
        end else begin
          res_o = trial;
        end
      end
      default: begin
        res_o  = '0;
        flag_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/tensor_gather_engine_top.sv
// ----------------------------------------------------------------------------
// tensor_gather_engine_top: gather engine with batch dimensions
// Stores data and index words, and answers reads of a gathered output element
// by splitting the output index, fetching the gather index and the data word.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_axis    in         tvalid/tready        tdata: address, data_word, index_word
//                                            tuser: operation
//  m_axis    out        tvalid/tready        tdata: gathered_word; tuser: status
//  cfg       in         cfg_we_i             cfg_idx_i, cfg_data_i
//
//  A write checks its address, stores the word and returns a status. A read
//  forms the output size, splits the output index with the 16-step shared
//  divider over four dimensions, forms the index address and reads the index
//  store, then forms the data address and reads the data store. The block
//  takes one request at a time; a finished result waits in the output register
//  while the next request is accepted. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module tensor_gather_engine_top #(
  parameter int DATA_DEPTH    = tge_pkg::DATA_DEPTH_DEF,
  parameter int INDEX_DEPTH   = tge_pkg::INDEX_DEPTH_DEF,
  parameter int ELEMENT_WIDTH = tge_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // address[15:0], data_word[47:16], index_word[79:48]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // gathered_word[31:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import tge_pkg::*;

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int IAW = $clog2(INDEX_DEPTH);
  localparam int KW  = $clog2(MAX_RANK);
  localparam logic [UNIT_W-1:0] DATA_LIM  = UNIT_W'(DATA_DEPTH);
  localparam logic [UNIT_W-1:0] INDEX_LIM = UNIT_W'(INDEX_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_EXEC = 10'b0000000010,
    S_SIZE = 10'b0000000100,
    S_DIV  = 10'b0000001000,
    S_POS  = 10'b0000010000,
    S_IRD  = 10'b0000100000,
    S_ADDR = 10'b0001000000,
    S_DRD  = 10'b0010000000,
    S_DONE = 10'b0100000000,
    S_SPR  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [RANK_W-1:0] data_rank_q, index_rank_q;
  logic [63:0]       data_dims_q, index_dims_q;
  logic [1:0]        gather_axis_q, batch_count_q;

  // Request and working registers
  logic [1:0]        op_q;
  logic [15:0]       addr_q;
  logic [31:0]       dword_q, iword_q;
  logic [UNIT_W-1:0] acc_q, acc_d, stride_q, stride_d, rem_q, rem_d;
  logic [15:0]       qd_q, qd_d, g_q, g_d;
  logic [DIM_W-1:0]  oc_q [MAX_RANK];
  logic [DIM_W-1:0]  oc_d [MAX_RANK];
  logic [KW-1:0]     k_q, k_d;
  logic [3:0]        bit_q, bit_d;
  logic              ph_q, ph_d;
  logic [31:0]       res_word_q, res_word_d;
  logic [1:0]        res_stat_q, res_stat_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_word_q;
  logic [1:0]        out_stat_q;

  // Shared unit connections
  unit_op_e          u_op;
  logic [UNIT_W-1:0] u_a, u_b, u_c, u_res;
  logic              u_flag;

  // Memory connections
  logic                     d_we, i_we;
  logic [ELEMENT_WIDTH-1:0] d_rdata;
  logic [31:0]              i_rdata;

  logic s_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Size of dimension idx of a packed shape; from index four on it reads as one
  function automatic logic [DIM_W-1:0] dim_of(logic [63:0] packed_dims, logic [4:0] idx);
    logic [DIM_W-1:0] r;
    r = 16'd1;
    if (idx < 5'd4) begin
      r = packed_dims[idx[1:0]*DIM_W +: DIM_W];
    end
    return r;
  endfunction

  // Check the configuration and derive the output shape
  logic             cfg_ok;
  logic [3:0]       out_rank;
  logic [DIM_W-1:0] shape [MAX_RANK];

  always_comb begin
    logic [4:0] ii;
    out_rank = 4'(data_rank_q) + 4'(index_rank_q) - 4'd1 - 4'(batch_count_q);
    cfg_ok = (data_rank_q != '0) && (data_rank_q <= RANK_W'(MAX_RANK)) &&
             (index_rank_q <= RANK_W'(MAX_RANK)) &&
             ({1'b0, gather_axis_q} < data_rank_q) &&
             (batch_count_q <= gather_axis_q) &&
             ({1'b0, batch_count_q} <= index_rank_q) &&
             (out_rank <= 4'(MAX_RANK));
    for (int i = 0; i < MAX_RANK; i++) begin
      if ((i < 3) && (2'(i) < batch_count_q) &&
          (dim_of(data_dims_q, 5'(i)) != dim_of(index_dims_q, 5'(i)))) begin
        cfg_ok = 1'b0;
      end
    end
    for (int i = 0; i < MAX_RANK; i++) begin
      ii = 5'(i);
      if (ii < 5'(gather_axis_q)) begin
        shape[i] = dim_of(data_dims_q, ii);
      end else if (ii + 5'(batch_count_q) < 5'(gather_axis_q) + 5'(index_rank_q)) begin
        shape[i] = dim_of(index_dims_q, 5'(batch_count_q) + ii - 5'(gather_axis_q));
      end else begin
        shape[i] = dim_of(data_dims_q, 5'(batch_count_q) + 5'd1 + ii - 5'(index_rank_q));
      end
      if (5'(i) >= 5'(out_rank)) begin
        shape[i] = 16'd1;
      end
    end
  end

  // Coordinates and sizes for the index and data linear addresses
  logic [DIM_W-1:0] pos_c, pos_dim, dat_c, dat_dim;
  always_comb begin
    logic [3:0] di;
    pos_c   = '0;
    pos_dim = 16'd1;
    if ({1'b0, k_q} < index_rank_q) begin
      pos_dim = dim_of(index_dims_q, 5'(k_q));
      if (k_q < batch_count_q) begin
        pos_c = oc_q[k_q];
      end else begin
        pos_c = oc_q[KW'(gather_axis_q - batch_count_q + k_q)];
      end
    end
    dat_c   = '0;
    dat_dim = 16'd1;
    di      = 4'(index_rank_q) + 4'(k_q) - 4'(batch_count_q) - 4'd1;
    if ({1'b0, k_q} < data_rank_q) begin
      dat_dim = dim_of(data_dims_q, 5'(k_q));
      if (k_q < gather_axis_q) begin
        dat_c = oc_q[k_q];
      end else if (k_q == gather_axis_q) begin
        dat_c = g_q;
      end else begin
        dat_c = oc_q[di[KW-1:0]];
      end
    end
  end

  // Gather index with negative fix-up
  logic [DIM_W-1:0]  axsz;
  logic signed [32:0] g_fix;
  logic              g_bad;
  always_comb begin
    axsz  = dim_of(data_dims_q, 5'(gather_axis_q));
    g_fix = $signed({i_rdata[31], i_rdata});
    if (i_rdata[31]) begin
      g_fix = g_fix + $signed({17'b0, axsz});
    end
    g_bad = (g_fix < 0) || (g_fix >= $signed({17'b0, axsz}));
  end

  // Feed the shared unit by state
  always_comb begin
    u_op = UNIT_MAC;
    u_a  = '0;
    u_b  = '0;
    u_c  = '0;
    unique case (state_q)
      S_SIZE: begin
        u_a = acc_q;
        u_b = UNIT_W'(shape[k_q]);
      end
      S_DIV: begin
        u_op = UNIT_DIV;
        u_a  = rem_q;
        u_b  = UNIT_W'(shape[k_q]);
        u_c  = UNIT_W'(qd_q[15]);
      end
      S_POS: begin
        u_a = ph_q ? stride_q : UNIT_W'(pos_c);
        u_b = ph_q ? UNIT_W'(pos_dim) : stride_q;
        u_c = ph_q ? '0 : acc_q;
      end
      S_ADDR: begin
        u_a = ph_q ? stride_q : UNIT_W'(dat_c);
        u_b = ph_q ? UNIT_W'(dat_dim) : stride_q;
        u_c = ph_q ? '0 : acc_q;
      end
      default: begin
        u_op = UNIT_MAC;
      end
    endcase
  end

  tge_unit u_unit (
    .op_i   (u_op),
    .a_i    (u_a),
    .b_i    (u_b),
    .c_i    (u_c),
    .res_o  (u_res),
    .flag_o (u_flag)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    stride_d    = stride_q;
    rem_d       = rem_q;
    qd_d        = qd_q;
    g_d         = g_q;
    k_d         = k_q;
    bit_d       = bit_q;
    ph_d        = ph_q;
    res_word_d  = res_word_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q;
    d_we        = 1'b0;
    i_we        = 1'b0;
    for (int i = 0; i < MAX_RANK; i++) begin
      oc_d[i] = oc_q[i];
    end
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_word_d = '0;
        res_stat_d = ST_OK;
        state_d    = S_DONE;
        case (op_q)
          OP_WR_DATA: begin
            if (UNIT_W'(addr_q) < DATA_LIM) begin
              d_we = 1'b1;
            end else begin
              res_stat_d = ST_ADDR;
            end
          end
          OP_WR_INDEX: begin
            if (UNIT_W'(addr_q) < INDEX_LIM) begin
              i_we = 1'b1;
            end else begin
              res_stat_d = ST_ADDR;
            end
          end
          OP_READ: begin
            if (cfg_ok) begin
              acc_d   = UNIT_W'(1);
              k_d     = '0;
              state_d = S_SIZE;
            end else begin
              res_stat_d = ST_ADDR;
            end
          end
          default: begin
            res_stat_d = ST_OK;
          end
        endcase
      end
      S_SIZE: begin
        acc_d = u_res;
        k_d   = k_q + 1'b1;
        if (k_q == KW'(MAX_RANK - 1)) begin
          if (UNIT_W'(addr_q) >= u_res) begin
            res_stat_d = ST_ADDR;
            state_d    = S_DONE;
          end else begin
            // split from the innermost dimension outward
            rem_d   = '0;
            qd_d    = addr_q;
            bit_d   = '0;
            k_d     = KW'(MAX_RANK - 1);
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d = u_res;
        qd_d  = {qd_q[14:0], u_flag};
        bit_d = bit_q + 1'b1;
        if (bit_q == 4'hF) begin
          oc_d[k_q] = u_res[DIM_W-1:0];
          rem_d     = '0;
          k_d       = k_q - 1'b1;
          if (k_q == '0) begin
            acc_d    = '0;
            stride_d = UNIT_W'(1);
            ph_d     = 1'b0;
            state_d  = S_POS;
          end
        end
      end
      S_POS: begin
        ph_d = ~ph_q;
        if (!ph_q) begin
          acc_d = u_res;
        end else begin
          stride_d = u_res;
          k_d      = k_q - 1'b1;
          if (k_q == '0) begin
            if (acc_q >= INDEX_LIM) begin
              res_stat_d = ST_ADDR;
              state_d    = S_DONE;
            end else begin
              state_d = S_IRD;
            end
          end
        end
      end
      S_IRD: begin
        if (g_bad) begin
          res_stat_d = ST_RANGE;
          state_d    = S_DONE;
        end else begin
          g_d      = g_fix[15:0];
          acc_d    = '0;
          stride_d = UNIT_W'(1);
          ph_d     = 1'b0;
          state_d  = S_ADDR;
        end
      end
      S_ADDR: begin
        ph_d = ~ph_q;
        if (!ph_q) begin
          acc_d = u_res;
        end else begin
          stride_d = u_res;
          k_d      = k_q - 1'b1;
          if (k_q == '0) begin
            if (acc_q >= DATA_LIM) begin
              res_stat_d = ST_ADDR;
              state_d    = S_DONE;
            end else begin
              state_d = S_DRD;
            end
          end
        end
      end
      S_DRD: begin
        res_word_d = 32'(d_rdata);
        res_stat_d = ST_OK;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = S_SPR;
        end
      end
      S_SPR: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      data_rank_q   <= RANK_W'(1);
      data_dims_q   <= 64'd1;
      index_rank_q  <= '0;
      index_dims_q  <= '0;
      gather_axis_q <= '0;
      batch_count_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DATA_RANK:   data_rank_q   <= cfg_data_i[RANK_W-1:0];
          REG_DATA_DIMS:   data_dims_q   <= cfg_data_i;
          REG_INDEX_RANK:  index_rank_q  <= cfg_data_i[RANK_W-1:0];
          REG_INDEX_DIMS:  index_dims_q  <= cfg_data_i;
          REG_GATHER_AXIS: gather_axis_q <= cfg_data_i[1:0];
          REG_BATCH_COUNT: batch_count_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q    <= s_axis_tuser;
      addr_q  <= s_axis_tdata[15:0];
      dword_q <= s_axis_tdata[47:16];
      iword_q <= s_axis_tdata[79:48];
    end
    acc_q      <= acc_d;
    stride_q   <= stride_d;
    rem_q      <= rem_d;
    qd_q       <= qd_d;
    g_q        <= g_d;
    k_q        <= k_d;
    bit_q      <= bit_d;
    ph_q       <= ph_d;
    res_word_q <= res_word_d;
    res_stat_q <= res_stat_d;
    for (int i = 0; i < MAX_RANK; i++) begin
      oc_q[i] <= oc_d[i];
    end
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
      out_word_q <= res_word_q;
      out_stat_q <= res_stat_q;
    end
  end

  // Data and index stores
  tge_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (addr_q[DAW-1:0]),
    .wdata_i (dword_q[ELEMENT_WIDTH-1:0]),
    .raddr_i (acc_q[DAW-1:0]),
    .rdata_o (d_rdata)
  );

  tge_ram #(
    .WIDTH (32),
    .DEPTH (INDEX_DEPTH)
  ) u_index_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (addr_q[IAW-1:0]),
    .wdata_i (iword_q),
    .raddr_i (acc_q[IAW-1:0]),
    .rdata_o (i_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tensor gather engine
// Drives store writes and gather reads over the request stream, predicts each
// result from a local copy of both stores and the shape registers, and checks
// every result in order under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;
  import tge_pkg::*;

  localparam int  DDEPTH    = DATA_DEPTH_DEF;
  localparam int  IDEPTH    = INDEX_DEPTH_DEF;
  localparam int  FILL_CAP  = 32;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  status;
  } gather_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // address[15:0], data_word[47:16], index_word[79:48]
  logic [1:0]  s_axis_tuser;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // gathered_word[31:0]
  logic [1:0]  m_axis_tuser;   // status[1:0]
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  // Local copy of stores and shape registers
  logic [31:0] data_mem [DDEPTH];
  logic [31:0] idx_mem  [IDEPTH];
  bit          data_wr  [DDEPTH];
  bit          idx_wr   [IDEPTH];
  int          sh_drank, sh_irank, sh_axis, sh_batch;
  logic [63:0] sh_ddims, sh_idims;

  gather_res_t pending_results[$];
  gather_res_t got_res;
  gather_res_t want_res;
  int          err_cnt;
  int          src_idle_pct;
  int          snk_stall_pct;
  longint      cycle_cnt = 0;

  tensor_gather_engine_top uut (.*);

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    err_cnt++;
  endtask

  // Check each result against the oldest prediction; stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.word   = m_axis_tdata;
      got_res.status = m_axis_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.word !== want_res.word)
          report_mismatch($sformatf("word %h, predicted %h", got_res.word, want_res.word));
        if (got_res.status !== want_res.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    got_res.status, want_res.status));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic longint dim_at(input logic [63:0] packed_dims, input int i);
    if (i >= 4) return 1;
    return longint'(packed_dims[16*i +: 16]);
  endfunction

  function automatic bit shape_ok();
    if (sh_drank == 0 || sh_drank > MAX_RANK) return 0;
    if (sh_irank > MAX_RANK) return 0;
    if (sh_axis >= sh_drank) return 0;
    if (sh_batch > sh_axis || sh_batch > sh_irank) return 0;
    for (int i = 0; i < sh_batch; i++)
      if (dim_at(sh_ddims, i) != dim_at(sh_idims, i)) return 0;
    if (sh_drank + sh_irank - 1 - sh_batch > MAX_RANK) return 0;
    return 1;
  endfunction

  // Output shape and its element count, saturated at 2**16
  function automatic longint out_shape(output longint shp[4], output int erank);
    int     orank;
    longint sz;
    orank = sh_drank + sh_irank - 1 - sh_batch;
    for (int i = 0; i < 4; i++) shp[i] = 1;
    for (int i = 0; i < orank; i++) begin
      if (i < sh_axis) shp[i] = dim_at(sh_ddims, i);
      else if (i < sh_axis + sh_irank - sh_batch)
        shp[i] = dim_at(sh_idims, sh_batch + i - sh_axis);
      else shp[i] = dim_at(sh_ddims, sh_batch + 1 + i - sh_irank);
    end
    erank = (orank == 0) ? 1 : orank;
    sz = 1;
    for (int i = 0; i < erank; i++) begin
      sz = sz * shp[i];
      if (sz > 65536) sz = 65536;
    end
    return sz;
  endfunction

  // Gathered element for an output index; hole flags a read of an unwritten entry
  function automatic void gather_predict(input logic [15:0] lin, output logic [31:0] word,
                                         output logic [1:0] st, output bit hole);
    longint          shp[4];
    longint unsigned oc[4];
    int              erank, d;
    longint          sz, g, axsz;
    longint unsigned rem, pos, stride, addr, c;
    word = '0;
    st   = ST_OK;
    hole = 0;
    if (!shape_ok()) begin
      st = ST_ADDR;
      return;
    end
    sz = out_shape(shp, erank);
    if (longint'(lin) >= sz) begin
      st = ST_ADDR;
      return;
    end
    for (int k = 0; k < 4; k++) oc[k] = 0;
    rem = lin;
    for (int k = erank; k > 0; k--) begin
      oc[k-1] = rem % longint'(shp[k-1]);
      rem     = rem / longint'(shp[k-1]);
    end
    // position in the indices tensor
    pos = 0;
    stride = 1;
    for (int k = sh_irank; k > 0; k--) begin
      d = k - 1;
      c = (d < sh_batch) ? oc[d] : oc[(sh_axis - sh_batch + d) % MAX_RANK];
      pos = pos + c * stride;
      stride = stride * dim_at(sh_idims, d);
    end
    if (pos >= IDEPTH) begin
      st = ST_ADDR;
      return;
    end
    if (!idx_wr[pos]) begin
      hole = 1;
      return;
    end
    g = longint'($signed(idx_mem[pos]));
    axsz = dim_at(sh_ddims, sh_axis);
    if (g < 0) g = g + axsz;
    if (g < 0 || g >= axsz) begin
      st = ST_RANGE;
      return;
    end
    // position in the data tensor
    addr = 0;
    stride = 1;
    for (int k = sh_drank; k > 0; k--) begin
      d = k - 1;
      if (d < sh_axis) c = oc[d];
      else if (d == sh_axis) c = g;
      else c = oc[(sh_irank - sh_batch + d - 1) % MAX_RANK];
      addr = addr + c * stride;
      stride = stride * dim_at(sh_ddims, d);
    end
    if (addr >= DDEPTH) begin
      st = ST_ADDR;
      return;
    end
    if (!data_wr[addr]) begin
      hole = 1;
      return;
    end
    word = data_mem[addr];
  endfunction

  // Send one request; a read that would touch an unwritten entry is dropped
  task automatic send_req(input logic [1:0] op, input logic [15:0] addr,
                          input logic [31:0] dw, input logic [31:0] iw, output bit sent);
    gather_res_t res;
    bit          hole;
    res  = '0;
    hole = 0;
    sent = 0;
    case (op)
      OP_WR_DATA: begin
        if (addr < DDEPTH) begin
          data_mem[addr] = dw;
          data_wr[addr]  = 1;
        end else res.status = ST_ADDR;
      end
      OP_WR_INDEX: begin
        if (addr < IDEPTH) begin
          idx_mem[addr] = iw;
          idx_wr[addr]  = 1;
        end else res.status = ST_ADDR;
      end
      OP_READ: gather_predict(addr, res.word, res.status, hole);
      default: ;
    endcase
    if (hole) return;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {iw, dw, addr};
    s_axis_tuser  <= op;
    pending_results.insert(pending_results.size(), res);
    do @(posedge clk_i); while (!s_axis_tready);
    sent = 1;
  endtask

  // Hold the sender until every predicted result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_shape(input logic [63:0] dr, input logic [63:0] dd,
                             input logic [63:0] ir, input logic [63:0] id,
                             input logic [63:0] ax, input logic [63:0] bc);
    logic [63:0] vals [6];
    vals = '{dr, dd, ir, id, ax, bc};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sh_drank = int'(dr[2:0]);
    sh_ddims = dd;
    sh_irank = int'(ir[2:0]);
    sh_idims = id;
    sh_axis  = int'(ax[1:0]);
    sh_batch = int'(bc[1:0]);
  endtask

  // Gather index mostly within [-axis size, axis size), sometimes anything
  function automatic logic [31:0] rand_gidx(input longint axsz);
    if (axsz == 0 || $urandom_range(4) == 0) return $urandom;
    return 32'($urandom_range(2 * axsz - 1) - axsz);
  endfunction

  function automatic int fill_count(input int rank, input logic [63:0] dims);
    longint n;
    n = 1;
    for (int i = 0; i < rank && i < 4; i++) n = n * dim_at(dims, i);
    return (n > FILL_CAP) ? FILL_CAP : int'(n);
  endfunction

  // Configure, fill both stores, then mix random requests
  task automatic run_gather(input logic [63:0] dr, input logic [63:0] dd,
                            input logic [63:0] ir, input logic [63:0] id,
                            input logic [63:0] ax, input logic [63:0] bc, input int n_items);
    int     nd, ni, done, tries, r, erank;
    longint axsz, sz;
    longint shp[4];
    bit     sent;
    logic [15:0] a;
    apply_shape(dr, dd, ir, id, ax, bc);
    nd   = fill_count(sh_drank, sh_ddims);
    ni   = fill_count(sh_irank, sh_idims);
    axsz = dim_at(sh_ddims, sh_axis);
    for (int i = 0; i < nd; i++) send_req(OP_WR_DATA, 16'(i), $urandom, $urandom, sent);
    for (int i = 0; i < ni; i++) send_req(OP_WR_INDEX, 16'(i), $urandom, rand_gidx(axsz), sent);
    done  = 0;
    tries = 0;
    while (done < n_items && tries < 20 * n_items) begin
      tries++;
      r = $urandom_range(99);
      if (r < 65) begin
        sz = shape_ok() ? out_shape(shp, erank) : 0;
        if (sz > 0 && $urandom_range(7) != 0) a = 16'($urandom_range(sz - 1));
        else a = 16'($urandom);
        send_req(OP_READ, a, $urandom, $urandom, sent);
      end else if (r < 80) begin
        a = ($urandom_range(9) == 0 || nd == 0) ? 16'($urandom) : 16'($urandom_range(nd - 1));
        send_req(OP_WR_DATA, a, $urandom, $urandom, sent);
      end else if (r < 93) begin
        a = ($urandom_range(9) == 0 || ni == 0) ? 16'($urandom) : 16'($urandom_range(ni - 1));
        send_req(OP_WR_INDEX, a, $urandom, rand_gidx(axsz), sent);
      end else begin
        send_req(OP_UNKNOWN, 16'($urandom), $urandom, $urandom, sent);
      end
      if (sent) done++;
    end
    drain();
  endtask

  // Store extremes, default shape reads, index fix-up and unknown operation
  task automatic test_directed();
    bit sent;
    send_req(OP_WR_DATA, 16'd0, 32'hFFFF_FFFF, 32'h0, sent);
    send_req(OP_WR_DATA, 16'd4095, 32'h0, 32'hFFFF_FFFF, sent);
    send_req(OP_WR_DATA, 16'd4096, 32'hA5A5_A5A5, 32'h0, sent);
    send_req(OP_WR_DATA, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, sent);
    send_req(OP_WR_INDEX, 16'd0, 32'h0, 32'hFFFF_FFFF, sent);
    send_req(OP_WR_INDEX, 16'd1023, 32'h0, 32'h7FFF_FFFF, sent);
    send_req(OP_WR_INDEX, 16'd1024, 32'h0, 32'h1, sent);
    send_req(OP_WR_INDEX, 16'hFFFF, 32'h0, 32'h8000_0000, sent);
    send_req(OP_READ, 16'd0, 32'h0, 32'h0, sent);
    send_req(OP_WR_INDEX, 16'd0, 32'h0, 32'h1, sent);
    send_req(OP_READ, 16'd0, 32'h0, 32'h0, sent);
    send_req(OP_WR_INDEX, 16'd0, 32'h0, 32'h8000_0000, sent);
    send_req(OP_READ, 16'd0, 32'h0, 32'h0, sent);
    send_req(OP_WR_INDEX, 16'd0, 32'h0, 32'hFFFF_FFFE, sent);
    send_req(OP_READ, 16'd0, 32'h0, 32'h0, sent);
    send_req(OP_WR_INDEX, 16'd0, 32'h0, 32'h0, sent);
    send_req(OP_READ, 16'd1, 32'h0, 32'h0, sent);
    send_req(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, sent);
    send_req(OP_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, sent);
    send_req(OP_WR_DATA, 16'd0, 32'h5A5A_C3C3, 32'h0, sent);
    send_req(OP_READ, 16'd0, 32'h0, 32'h0, sent);
    drain();
  endtask

  // Gather along the last axis, no batch dims: data [3,4], indices [5]
  task automatic test_axis_gather();
    run_gather(2, {16'd0, 16'd0, 16'd4, 16'd3}, 1, {48'd0, 16'd5}, 1, 0, 10);
  endtask

  // Gather on axis 2 with one batch dim: data [2,3,2,2], indices [2,3]
  task automatic test_batch_gather();
    run_gather(4, {16'd2, 16'd2, 16'd3, 16'd2}, 2, {32'd0, 16'd3, 16'd2}, 2, 1, 10);
  endtask

  // Random small shapes, with an occasional empty dimension
  task automatic test_random_shapes();
    int          dr, ir, ax, bc;
    logic [63:0] dd, id;
    for (int n = 0; n < 2; n++) begin
      dr = $urandom_range(1, 4);
      ax = $urandom_range(0, dr - 1);
      ir = $urandom_range(0, 4);
      bc = $urandom_range(0, (ax < ir) ? ax : ir);
      dd = '0;
      id = '0;
      for (int i = 0; i < 4; i++) begin
        dd[16*i +: 16] = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        id[16*i +: 16] = 16'($urandom_range(1, 3));
      end
      for (int i = 0; i < bc; i++) id[16*i +: 16] = dd[16*i +: 16];
      run_gather(dr, dd, ir, id, ax, bc, 10);
    end
  endtask

  // Widest axis and batch settings with full-size dimensions
  task automatic test_wide_shapes();
    run_gather(4, {16'hFFFF, 16'd2, 16'd2, 16'd2}, 4, {16'hFFFF, 16'd2, 16'd2, 16'd2},
               3, 3, 10);
    run_gather(1, 64'hFFFF_FFFF_FFFF_FFFF, 4, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 5);
  endtask

  // Several kinds of invalid shape setting, each rejecting every read
  task automatic test_bad_config();
    run_gather(0, 64'h1, 0, 64'h0, 0, 0, 3);
    run_gather(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0, 0, 0, 3);
    run_gather(2, 64'h0003_0002, 5, 64'h1, 0, 0, 3);
    run_gather(2, 64'h0003_0002, 1, 64'h2, 2, 0, 3);
    run_gather(3, 64'h0002_0003_0002, 1, 64'h2, 1, 2, 3);
    run_gather(3, 64'h0002_0003_0002, 2, 64'h0002_0003, 1, 1, 3);
    run_gather(4, 64'h0002_0002_0002_0002, 4, 64'h0002_0002_0002_0002, 1, 0, 3);
  endtask

  initial begin
    int idle_mix [4][2];
    idle_mix = '{'{0, 0}, '{74, 0}, '{0, 74}, '{14, 14}};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    err_cnt = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // reset state of the shape registers
    sh_drank = 1;
    sh_ddims = 64'h1;
    sh_irank = 0;
    sh_idims = '0;
    sh_axis  = 0;
    sh_batch = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = idle_mix[ph][0];
      snk_stall_pct = idle_mix[ph][1];
      test_axis_gather();
      test_batch_gather();
      test_random_shapes();
    end
    test_wide_shapes();
    test_bad_config();

    drain();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tge_pkg.sv
rtl/core/tge_ram.sv
rtl/core/tge_unit.sv
rtl/core/tensor_gather_engine_top.sv
tb/tb.sv
